FILE: design/hjte_pkg.sv
`timescale 1ns / 1ps
package hjte_pkg;

    localparam int KEY_W  = 32;
    localparam int ROW_W  = 32;
    localparam int KIND_W = 3;
    localparam int TB_W   = 4;
    localparam int MP_W   = 11;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_PROBE  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAIR      = 3'd0,
        KIND_NO_MATCH  = 3'd1,
        KIND_INSERTED  = 3'd2,
        KIND_DUP       = 3'd3,
        KIND_FULL      = 3'd4,
        KIND_CHAIN_FUL = 3'd5,
        KIND_CLEARED   = 3'd6,
        KIND_TRUNC     = 3'd7
    } kind_t;

    typedef enum logic {
        CFG_TABLE_BITS = 1'b0,
        CFG_PROBE_CAP  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_CLEAR,
        ST_RD,
        ST_CHK,
        ST_CRD,
        ST_CCHK,
        ST_OUT
    } state_t;

    localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic hash1;
        logic hash2;
        logic hash3;
        logic clr_start;
        logic clr_step;
        logic slot_rd;
        logic slot_step;
        logic slot_write;
        logic dup_write;
        logic match_load;
        logic chain_rd;
        logic chain_adv;
        logic clr_chain;
        logic set_out;
        logic [KIND_W-1:0] out_kind;
        logic out_pair;
        logic out_last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic slot_valid;
        logic key_eq;
        logic probe_done;
        logic all_done;
        logic chain_full;
        logic more;
        logic cap_hit;
    } dp_stat_t;

endpackage

FILE: design/hjte_if.sv
`timescale 1ns / 1ps
interface hjte_req_if;
    import hjte_pkg::*;
    logic valid;
    logic ready;
    logic [1:0] req_type;
    logic signed [KEY_W-1:0] search_key;
    logic [ROW_W-1:0] row_index;
    modport source (output valid, req_type, search_key, row_index, input ready);
    modport sink   (input valid, req_type, search_key, row_index, output ready);
endinterface

interface hjte_res_if;
    import hjte_pkg::*;
    logic valid;
    logic ready;
    logic [KIND_W-1:0] result_kind;
    logic [ROW_W-1:0] build_row;
    logic [ROW_W-1:0] probe_row;
    logic last;
    modport source (output valid, result_kind, build_row, probe_row, last, input ready);
    modport sink   (input valid, result_kind, build_row, probe_row, last, output ready);
endinterface

interface hjte_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/hjte_datapath.sv
`timescale 1ns / 1ps
module hjte_datapath #(
    parameter int LOG2_SLOTS  = 10,
    parameter int CHAIN_DEPTH = 256,
    parameter int MAX_MATCHES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hjte_pkg::dp_cmd_t         cmd,
    output hjte_pkg::dp_stat_t        stat,
    input  logic [31:0]               in_key,
    input  logic [31:0]               in_row,
    input  logic [hjte_pkg::TB_W-1:0] table_bits,
    input  logic [hjte_pkg::MP_W-1:0] probe_cap,
    output logic [hjte_pkg::KIND_W-1:0] out_kind,
    output logic [31:0]               out_brow,
    output logic [31:0]               out_prow,
    output logic                      out_last
);
    import hjte_pkg::*;

    localparam int SLOTS = 1 << LOG2_SLOTS;
    localparam int CW    = $clog2(CHAIN_DEPTH + 1);  // link incl. end marker
    localparam int CA    = $clog2(CHAIN_DEPTH);
    localparam int PW    = LOG2_SLOTS + 1;
    localparam int MW    = $clog2(MAX_MATCHES + 1);
    localparam logic [CW-1:0] CHAIN_END = CW'(CHAIN_DEPTH);

    // memories; slot valid bits are wiped by a sweep after reset and on clear
    logic          valid_mem[SLOTS];
    logic [31:0]   key_mem  [SLOTS];
    logic [31:0]   row_mem  [SLOTS];
    logic [CW-1:0] head_mem [SLOTS];
    logic [31:0]   crow_mem [CHAIN_DEPTH];
    logic [CW-1:0] cnext_mem[CHAIN_DEPTH];

    logic [31:0] key_reg, row_reg, h_reg;
    logic [LOG2_SLOTS-1:0] slot_reg, mask;
    logic [PW-1:0] step_reg, limit;
    logic [31:0] rd_key_reg, rd_row_reg;
    logic [CW-1:0] rd_head_reg, link_reg;
    logic rd_valid_reg;
    logic [31:0] crd_row_reg;
    logic [CW-1:0] crd_next_reg;
    logic [31:0] brow_reg;
    logic [MW-1:0] n_reg;
    logic [CW-1:0] used_reg;
    logic [KIND_W-1:0] okind_reg;
    logic [31:0] obrow_reg, oprow_reg;
    logic olast_reg;

    logic [TB_W-1:0] bits;
    logic [PW-1:0] slots_used, mp;
    logic [31:0] h1, h2;

    always_comb
    begin
        bits = table_bits;
        if (bits == '0) bits = TB_W'(1);
        if (32'(bits) > 32'(LOG2_SLOTS)) bits = TB_W'(LOG2_SLOTS);
        slots_used = PW'(1) << bits;
        mask = LOG2_SLOTS'(slots_used - PW'(1));
        mp = (probe_cap == '0) ? PW'(1) :
             ((32'(probe_cap) > 32'(slots_used)) ? slots_used : PW'(probe_cap));
        limit = mp;
        h1 = h_reg ^ (h_reg >> 13);
        h2 = h_reg ^ (h_reg >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg <= in_key;
            row_reg <= in_row;
            h_reg   <= in_key ^ (in_key >> 16);
        end
        else if (cmd.hash1)
            h_reg <= h_reg * MIX_C1;
        else if (cmd.hash2)
            h_reg <= h1 * MIX_C2;
        else if (cmd.hash3)
            h_reg <= h2;
        if (cmd.slot_rd)
        begin
            rd_valid_reg <= valid_mem[slot_reg];
            rd_key_reg   <= key_mem[slot_reg];
            rd_row_reg   <= row_mem[slot_reg];
            rd_head_reg  <= head_mem[slot_reg];
        end
        if (cmd.clr_step || cmd.slot_write)
            valid_mem[slot_reg] <= cmd.slot_write;
        if (cmd.slot_write)
        begin
            key_mem[slot_reg] <= key_reg;
            row_mem[slot_reg] <= row_reg;
        end
        if (cmd.slot_write || cmd.dup_write)
            head_mem[slot_reg] <= cmd.slot_write ? CHAIN_END : used_reg;
        if (cmd.dup_write)
        begin
            crow_mem[CA'(used_reg)]  <= row_reg;
            cnext_mem[CA'(used_reg)] <= rd_head_reg;
        end
        if (cmd.chain_rd)
        begin
            crd_row_reg  <= crow_mem[CA'(link_reg)];
            crd_next_reg <= cnext_mem[CA'(link_reg)];
        end
        if (cmd.set_out)
        begin
            okind_reg <= cmd.out_kind;
            obrow_reg <= cmd.out_pair ? brow_reg : '0;
            oprow_reg <= cmd.out_pair ? row_reg : '0;
            olast_reg <= cmd.out_last;
        end
    end

    // slot walk and match walk bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            step_reg <= '0;
            used_reg <= '0;
            link_reg <= '0;
            brow_reg <= '0;
            n_reg    <= '0;
        end
        else
        begin
            // clear sweep covers every slot, not only those in use
            if (cmd.clr_start)
                slot_reg <= '0;
            else if (cmd.hash3)
                slot_reg <= LOG2_SLOTS'(h2) & mask;
            else if (cmd.clr_step)
                slot_reg <= slot_reg + LOG2_SLOTS'(1);
            else if (cmd.slot_step)
                slot_reg <= (slot_reg + LOG2_SLOTS'(1)) & mask;
            if (cmd.load_req)
                step_reg <= '0;
            else if (cmd.slot_step)
                step_reg <= step_reg + PW'(1);
            if (cmd.clr_chain)
                used_reg <= '0;
            else if (cmd.dup_write)
                used_reg <= used_reg + CW'(1);
            if (cmd.match_load)
            begin
                brow_reg <= rd_row_reg;
                link_reg <= rd_head_reg;
                n_reg    <= '0;
            end
            else if (cmd.chain_adv)
            begin
                brow_reg <= crd_row_reg;
                link_reg <= crd_next_reg;
                n_reg    <= n_reg + MW'(1);
            end
        end
    end

    assign stat.clr_done   = (slot_reg == LOG2_SLOTS'(SLOTS - 1));
    assign stat.slot_valid = rd_valid_reg;
    assign stat.key_eq     = (rd_key_reg == key_reg);
    assign stat.probe_done = (step_reg + PW'(1) >= limit);
    assign stat.all_done   = (step_reg + PW'(1) >= slots_used);
    assign stat.chain_full = (32'(used_reg) >= 32'(CHAIN_DEPTH));
    assign stat.more       = (link_reg < CHAIN_END);
    assign stat.cap_hit    = (32'(n_reg) == 32'(MAX_MATCHES - 1));

    assign out_kind = okind_reg;
    assign out_brow = obrow_reg;
    assign out_prow = oprow_reg;
    assign out_last = olast_reg;
endmodule

FILE: design/hjte_ctrl.sv
`timescale 1ns / 1ps
module hjte_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output hjte_pkg::dp_cmd_t  cmd,
    input  hjte_pkg::dp_stat_t stat
);
    import hjte_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;
    req_t req_reg, req_next;
    kind_t pkind_reg, pkind_next;   // beat waiting for the result register
    logic plast_reg, plast_next;
    logic ppair_reg, ppair_next;
    logic ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
            ret_reg   <= ST_IDLE;
            req_reg   <= REQ_NONE;
            pkind_reg <= KIND_PAIR;
            plast_reg <= 1'b0;
            ppair_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            req_reg   <= req_next;
            pkind_reg <= pkind_next;
            plast_reg <= plast_next;
            ppair_reg <= ppair_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        req_next   = req_reg;
        pkind_next = pkind_reg;
        plast_next = plast_reg;
        ppair_next = ppair_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_WIPE:
            begin
                // valid bits swept once after reset, no result
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    req_next = req_t'(in_req);
                    priority case (req_t'(in_req))
                        REQ_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        REQ_INSERT, REQ_PROBE: state_next = ST_HASH1;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HASH1:
            begin
                cmd.hash1 = 1'b1;
                state_next = ST_HASH2;
            end
            ST_HASH2:
            begin
                cmd.hash2 = 1'b1;
                state_next = ST_HASH3;
            end
            ST_HASH3:
            begin
                cmd.hash3 = 1'b1;
                state_next = ST_RD;
            end
            ST_CLEAR:
            begin
                // sweep from slot 0 over every slot
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    cmd.clr_chain = 1'b1;
                    pkind_next = KIND_CLEARED;
                    plast_next = 1'b1;
                    ppair_next = 1'b0;
                    ret_next = ST_IDLE;
                    state_next = ST_OUT;
                end
            end
            ST_RD:
            begin
                cmd.slot_rd = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                plast_next = 1'b1;
                ppair_next = 1'b0;
                ret_next = ST_IDLE;
                state_next = ST_OUT;
                if (req_reg == REQ_INSERT)
                begin
                    if (!stat.slot_valid)
                    begin
                        cmd.slot_write = 1'b1;
                        pkind_next = KIND_INSERTED;
                    end
                    else if (stat.key_eq)
                    begin
                        cmd.dup_write = !stat.chain_full;
                        pkind_next = stat.chain_full ? KIND_CHAIN_FUL : KIND_DUP;
                    end
                    else if (stat.all_done)
                        pkind_next = KIND_FULL;
                    else
                    begin
                        cmd.slot_step = 1'b1;
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    if (!stat.slot_valid)
                        pkind_next = KIND_NO_MATCH;
                    else if (stat.key_eq)
                    begin
                        cmd.match_load = 1'b1;
                        state_next = ST_CCHK;
                    end
                    else if (stat.probe_done)
                        pkind_next = KIND_NO_MATCH;
                    else
                    begin
                        cmd.slot_step = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_CCHK:
            begin
                // brow/link now hold current entry
                ppair_next = 1'b1;
                if (stat.cap_hit || !stat.more)
                begin
                    pkind_next = stat.more ? KIND_TRUNC : KIND_PAIR;
                    plast_next = 1'b1;
                    ret_next = ST_IDLE;
                end
                else
                begin
                    pkind_next = KIND_PAIR;
                    plast_next = 1'b0;
                    cmd.chain_rd = 1'b1;
                    ret_next = ST_CRD;
                end
                state_next = ST_OUT;
            end
            ST_CRD:
            begin
                cmd.chain_adv = 1'b1;
                state_next = ST_CCHK;
            end
            ST_OUT:
            begin
                // result register loads once it is free or being drained
                if (!ov_reg || out_ready)
                begin
                    cmd.set_out = 1'b1;
                    cmd.out_kind = pkind_reg;
                    cmd.out_pair = ppair_reg;
                    cmd.out_last = plast_reg;
                    ov_next = 1'b1;
                    state_next = (ret_reg == ST_CRD) ? ST_CRD : ST_IDLE;
                    ret_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
endmodule

FILE: design/hash_join_table_engine.sv
`timescale 1ns / 1ps
// Hash join table engine: requests (clear, insert, probe) enter one at a time on req;
// results leave on res, each probe match as its own beat, last beat marked.
// After reset the engine sweeps all 2**LOG2_SLOTS slot valid bits, one per cycle,
// with req.ready low. An insert runs the hash steps (two registered fmix32
// multiplies and a final xor-shift), then a read and a compare per table slot
// examined, then a load of the result register; a probe hit adds a chain check
// before the first pair, then each chained match takes a chain read, a compare
// and a result load. A new request is taken only once the last one's final
// result is loaded. A clear sweeps all 2**LOG2_SLOTS slots, one per cycle.
// Slot and chain memory read ports set the per-step cost. A stalled result holds
// the engine in its output state, which in turn holds off req. Write
// configuration only while no request is in flight.
module hash_join_table_engine #(
    parameter int LOG2_SLOTS  = 10,
    parameter int CHAIN_DEPTH = 256,
    parameter int MAX_MATCHES = 64
) (
    input logic       clk,
    input logic       rst_n,
    hjte_req_if.sink  req,
    hjte_res_if.source res,
    hjte_cfg_if.sink  cfg
);
    import hjte_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [TB_W-1:0] table_bits_reg;
    logic [MP_W-1:0] probe_cap_reg;
    logic [KIND_W-1:0] okind;
    logic [31:0] obrow, oprow;
    logic olast;

    // config writes always accepted
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_bits_reg <= TB_W'(10);
            probe_cap_reg  <= MP_W'(32);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_TABLE_BITS: table_bits_reg <= cfg.data[TB_W-1:0];
                CFG_PROBE_CAP:  probe_cap_reg  <= cfg.data;
            endcase
        end
    end

    hjte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_req    (req.req_type),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hjte_datapath #(
        .LOG2_SLOTS  (LOG2_SLOTS),
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_key     (req.search_key),
        .in_row     (req.row_index),
        .table_bits (table_bits_reg),
        .probe_cap  (probe_cap_reg),
        .out_kind   (okind),
        .out_brow   (obrow),
        .out_prow   (oprow),
        .out_last   (olast)
    );

    assign res.result_kind = okind;
    assign res.build_row   = obrow;
    assign res.probe_row   = oprow;
    assign res.last        = olast;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result beat dropped");
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=>
            $stable({res.result_kind, res.build_row, res.probe_row, res.last}))
        else $error("result beat changed while stalled");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.slot_write && cmd.dup_write))
        else $error("insert and chain push together");
endmodule

FILE: test/hash_join_checker.sv
`timescale 1ns / 1ps
module hash_join_checker #(
    parameter int LOG2_SLOTS  = 10,
    parameter int CHAIN_DEPTH = 256,
    parameter int MAX_MATCHES = 64
) (
    input  logic clk,
    input  logic rst_n,
    hjte_req_if  req,
    hjte_res_if  res,
    hjte_cfg_if  cfg,
    output int   errors,
    output int   pending,
    output int   beats_seen,
    output int   trunc_seen,
    output int   full_seen,
    output int   chain_full_seen
);
    import hjte_pkg::*;

    localparam int SLOTS = 1 << LOG2_SLOTS;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  build_row;
        logic [ROW_W-1:0]  probe_row;
        logic              last;
    } join_beat_t;

    join_beat_t  expected_beats[$];

    logic [TB_W-1:0]  table_bits_reg;
    logic [MP_W-1:0]  probe_cap_reg;
    logic             occupied [SLOTS];
    logic [31:0]      key_at [SLOTS];
    logic [31:0]      row_at [SLOTS];
    int               head_at [SLOTS];
    logic [31:0]      chained_row [CHAIN_DEPTH];
    int               chained_next [CHAIN_DEPTH];
    int               chain_fill;

    function automatic logic [31:0] fmix(input logic [31:0] v);
        logic [31:0] h;
        h = v;
        h = h ^ (h >> 16);
        h = h * MIX_C1;
        h = h ^ (h >> 13);
        h = h * MIX_C2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic void push_beat(input kind_t k, input logic [31:0] b,
                                      input logic [31:0] p, input logic l);
        join_beat_t e;
        e.kind = k;
        e.build_row = b;
        e.probe_row = p;
        e.last = l;
        expected_beats.insert(expected_beats.size(), e);
    endfunction

    // Runs one request against the shadow table, queueing its result beats.
    function automatic void predict_request(input logic [1:0] kind_in,
                                            input logic [31:0] key,
                                            input logic [31:0] row);
        int bits;
        int nslots;
        int mask;
        int home;
        int s;
        int lim;
        int n;
        int link;
        logic [31:0] brow;
        bits = table_bits_reg;
        if (bits < 1) bits = 1;
        if (bits > LOG2_SLOTS) bits = LOG2_SLOTS;
        nslots = 1 << bits;
        mask = nslots - 1;
        home = fmix(key) & mask;
        case (kind_in)
            REQ_CLEAR:
            begin
                foreach (occupied[j]) occupied[j] = 1'b0;
                chain_fill = 0;
                push_beat(KIND_CLEARED, 0, 0, 1'b1);
            end
            REQ_INSERT:
            begin
                for (int i = 0; i < nslots; i++)
                begin
                    s = (home + i) & mask;
                    if (!occupied[s])
                    begin
                        occupied[s] = 1'b1;
                        key_at[s] = key;
                        row_at[s] = row;
                        head_at[s] = CHAIN_DEPTH;
                        push_beat(KIND_INSERTED, 0, 0, 1'b1);
                        return;
                    end
                    if (key_at[s] == key)
                    begin
                        if (chain_fill >= CHAIN_DEPTH)
                        begin
                            push_beat(KIND_CHAIN_FUL, 0, 0, 1'b1);
                            return;
                        end
                        chained_row[chain_fill] = row;
                        chained_next[chain_fill] = head_at[s];
                        head_at[s] = chain_fill;
                        chain_fill++;
                        push_beat(KIND_DUP, 0, 0, 1'b1);
                        return;
                    end
                end
                push_beat(KIND_FULL, 0, 0, 1'b1);
            end
            REQ_PROBE:
            begin
                lim = probe_cap_reg;
                if (lim < 1) lim = 1;
                if (lim > nslots) lim = nslots;
                for (int i = 0; i < lim; i++)
                begin
                    s = (home + i) & mask;
                    if (!occupied[s]) break;
                    if (key_at[s] == key)
                    begin
                        n = 0;
                        link = head_at[s];
                        brow = row_at[s];
                        forever
                        begin
                            if (n == MAX_MATCHES - 1 || link >= CHAIN_DEPTH)
                            begin
                                push_beat(link < CHAIN_DEPTH ? KIND_TRUNC : KIND_PAIR,
                                          brow, row, 1'b1);
                                return;
                            end
                            push_beat(KIND_PAIR, brow, row, 1'b0);
                            n++;
                            brow = chained_row[link];
                            link = chained_next[link];
                        end
                    end
                end
                push_beat(KIND_NO_MATCH, 0, 0, 1'b1);
            end
            default: ;  // unknown request: no beat, no change
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        join_beat_t e;
        if (!rst_n)
        begin
            table_bits_reg <= 4'd10;
            probe_cap_reg <= 11'd32;
            foreach (occupied[j]) occupied[j] = 1'b0;
            chain_fill = 0;
            expected_beats.delete();
            pending <= 0;
            errors <= 0;
            beats_seen <= 0;
            trunc_seen <= 0;
            full_seen <= 0;
            chain_full_seen <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_TABLE_BITS) table_bits_reg <= cfg.data[TB_W-1:0];
                else probe_cap_reg <= cfg.data;
            end
            if (req.valid && req.ready)
                predict_request(req.req_type, req.search_key, req.row_index);
            if (res.valid && res.ready)
            begin
                beats_seen <= beats_seen + 1;
                if (res.result_kind == KIND_TRUNC) trunc_seen <= trunc_seen + 1;
                if (res.result_kind == KIND_FULL) full_seen <= full_seen + 1;
                if (res.result_kind == KIND_CHAIN_FUL)
                    chain_full_seen <= chain_full_seen + 1;
                if (expected_beats.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result beat kind %0d", $time,
                                 res.result_kind);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (res.result_kind !== e.kind || res.build_row !== e.build_row ||
                        res.probe_row !== e.probe_row || res.last !== e.last)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch exp k%0d b%h p%h l%0d got k%0d b%h p%h l%0d",
                                     $time, e.kind, e.build_row, e.probe_row, e.last,
                                     res.result_kind, res.build_row, res.probe_row,
                                     res.last);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_beats.size();
        end
    end

endmodule

FILE: test/hash_join_table_engine_tb.sv
`timescale 1ns / 1ps
module hash_join_table_engine_tb;
    import hjte_pkg::*;

    localparam int LIMIT = 600000;   // cycles

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors, pending, beats_seen, trunc_seen, full_seen, chain_full_seen;
    int   items_sent;

    // calm: neither side idles; start_hold: receiver takes one long stall
    bit   calm;
    bit   start_hold;
    bit   hold_taken;
    int   hold_left;

    hjte_req_if req ();
    hjte_res_if res ();
    hjte_cfg_if cfg ();

    hash_join_table_engine uut (
        .clk(clk), .rst_n(rst_n), .req(req), .res(res), .cfg(cfg)
    );

    hash_join_checker chk (
        .clk(clk), .rst_n(rst_n), .req(req), .res(res), .cfg(cfg),
        .errors(errors), .pending(pending), .beats_seen(beats_seen),
        .trunc_seen(trunc_seen), .full_seen(full_seen),
        .chain_full_seen(chain_full_seen)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: ~9% random stalls, none in calm phases, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (start_hold && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= 2000;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("hash_join_table_engine_tb: FAIL");
            $finish;
        end
    end

    // Key pool: extremes plus a few others so inserts collide and chain up
    logic [31:0] key_pool [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                  32'hffff_ffff, 32'h1234_5678, 32'hdead_beef};

    // One request beat; holds valid until accepted
    task automatic send_req(input req_t kind, input logic [31:0] key,
                            input logic [31:0] row);
        if (!calm && $urandom_range(99) < 9)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= kind;
        req.search_key <= key;
        req.row_index <= row;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);   // settle before touching registers
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [10:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random phase; insert_pct sets the insert share, clears only if allowed
    task automatic random_phase(input int count, input int insert_pct, input bit clears);
        int r;
        req_t kind;
        logic [31:0] key;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (clears && r < 2) kind = REQ_CLEAR;
            else if (r < 5) kind = REQ_NONE;
            else if (r < 5 + insert_pct) kind = REQ_INSERT;
            else kind = REQ_PROBE;
            key = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(5)];
            send_req(kind, key, $urandom);
        end
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        items_sent = 0;
        calm = 1'b0;
        start_hold = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_NONE;
        req.search_key = '0;
        req.row_index = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_TABLE_BITS;
        cfg.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty probe, extreme keys and rows, duplicates, clear, ignore
        send_req(REQ_PROBE,  32'h0000_0000, 32'h0000_0001);
        send_req(REQ_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_req(REQ_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_req(REQ_INSERT, 32'h8000_0000, 32'haaaa_aaaa);
        send_req(REQ_INSERT, 32'h8000_0000, 32'h5555_5555);
        send_req(REQ_PROBE,  32'h8000_0000, 32'hffff_ffff);
        send_req(REQ_PROBE,  32'h7fff_ffff, 32'h0000_0000);
        send_req(REQ_PROBE,  32'h0000_0000, 32'h1234_5678);
        send_req(REQ_NONE,   32'hffff_ffff, 32'hffff_ffff);
        send_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0007);
        send_req(REQ_PROBE,  32'h0000_0000, 32'h8000_0000);
        send_req(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000);
        send_req(REQ_PROBE,  32'h8000_0000, 32'h0000_0002);
        send_req(REQ_INSERT, 32'hffff_ffff, 32'haaaa_aaaa);
        send_req(REQ_PROBE,  32'hffff_ffff, 32'h5555_5555);
        wait_drained();   // sender pauses until every result is back

        // Tiny table, probe limit at its top: table-full and wraparound
        write_reg(CFG_TABLE_BITS, 11'd2);
        write_reg(CFG_PROBE_CAP, 11'd2047);
        random_phase(60, 60, 1'b1);
        wait_drained();

        // Full table, single-slot probes; no idling on either side here
        calm = 1'b1;
        write_reg(CFG_TABLE_BITS, 11'd10);
        write_reg(CFG_PROBE_CAP, 11'd1);
        random_phase(60, 50, 1'b1);
        wait_drained();
        calm = 1'b0;

        // Out-of-range low settings on both registers
        write_reg(CFG_TABLE_BITS, 11'd0);
        write_reg(CFG_PROBE_CAP, 11'd0);
        random_phase(30, 50, 1'b1);
        wait_drained();

        // Chain stress: no random clears; heavy duplicate inserts build long match
        // chains. The receiver holds off first.
        write_reg(CFG_TABLE_BITS, 11'd15);
        write_reg(CFG_PROBE_CAP, 11'd32);
        send_req(REQ_CLEAR, 32'h0, 32'h0);
        start_hold = 1'b1;
        random_phase(200, 75, 1'b0);
        req.valid <= 1'b0;
        @(posedge clk);

        drain = 0;
        while (pending != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (50) @(posedge clk);

        $display("Ran %0d requests over %0d cycles, checked %0d result beats",
                 items_sent, cycles, beats_seen);
        $display("Saw %0d truncated pairs, %0d table-full, %0d chain-full results",
                 trunc_seen, full_seen, chain_full_seen);
        if (errors == 0 && pending == 0)
            $display("hash_join_table_engine_tb: PASS");
        else
            $display("hash_join_table_engine_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/hjte_pkg.sv
design/hjte_if.sv
design/hjte_datapath.sv
design/hjte_ctrl.sv
design/hash_join_table_engine.sv
test/hash_join_checker.sv
test/hash_join_table_engine_tb.sv
